FILE: rtl/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// Shared types and codes of the generational handle table: command and
// status codes and the beat layouts of the request and response channels.
// ----------------------------------------------------------------------------
`default_nettype none

package ght_pkg;

  localparam int unsigned CMD_W       = 2;
  localparam int unsigned IDX_FIELD_W = 8;
  localparam int unsigned GEN_FIELD_W = 16;
  localparam int unsigned TAG_W       = 32;
  localparam int unsigned STATUS_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RESOLVE = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NULL    = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    logic [CMD_W-1:0]       command;
    logic [IDX_FIELD_W-1:0] handle_index;
    logic [GEN_FIELD_W-1:0] handle_generation;
    logic [TAG_W-1:0]       resource_tag;
  } ght_in_t;

  typedef struct packed {
    status_e                status;
    logic [IDX_FIELD_W-1:0] out_index;
    logic [GEN_FIELD_W-1:0] out_generation;
    logic [TAG_W-1:0]       out_resource;
  } ght_out_t;

endpackage

`default_nettype wire

FILE: rtl/ght_ram.sv
// ----------------------------------------------------------------------------
// ght_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data and a read enable that holds the last word read.
// ----------------------------------------------------------------------------
`default_nettype none

module ght_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  parameter int unsigned AW    = 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/generational_handle_table_top.sv
// ----------------------------------------------------------------------------
// generational_handle_table_top
// Flow: an accepted command moves to S_EXEC, and its result beat is registered
// once the output register is free. No new command is accepted until then,
// as each command reads and then writes back one entry of the slot RAM and
// the free-stack RAM. Reset: control state clears at once; the RAMs need no
// clearing pass, since slots at or above the used count and stack entries at
// or above the fill count are never used.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_table_top #(
  parameter int unsigned SLOT_COUNT = 256,
  parameter int unsigned GEN_BITS   = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ght_pkg::ght_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ght_pkg::ght_out_t out_o
);

  import ght_pkg::*;

  localparam int unsigned IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W  = IDX_W + 1;
  localparam int unsigned HW     = (IDX_W > IDX_FIELD_W) ? IDX_W : IDX_FIELD_W;
  localparam int unsigned GW     = (GEN_BITS > GEN_FIELD_W) ? GEN_BITS : GEN_FIELD_W;
  localparam int unsigned SLOT_W = 1 + GEN_BITS + TAG_W;
  localparam int unsigned STK_W  = GEN_BITS + IDX_W;
  localparam logic [CNT_W-1:0] SLOT_MAX = CNT_W'(SLOT_COUNT);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e            state_q, state_d;
  ght_in_t           req_q;
  ght_out_t          out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic [CNT_W-1:0]  free_count_q, free_count_d;
  logic [CNT_W-1:0]  slots_used_q, slots_used_d;

  logic              accept, fire;
  logic [HW-1:0]     hidx_in, hidx;
  logic [CNT_W-1:0]  stk_top;

  logic              slot_we;
  logic [IDX_W-1:0]  slot_waddr;
  logic [SLOT_W-1:0] slot_wdata;
  logic [IDX_W-1:0]  slot_raddr;
  logic [SLOT_W-1:0] slot_rdata;
  logic              stk_we;
  logic [IDX_W-1:0]  stk_waddr;
  logic [STK_W-1:0]  stk_wdata;
  logic [IDX_W-1:0]  stk_raddr;
  logic [STK_W-1:0]  stk_rdata;

  logic                rd_alive;
  logic [GEN_BITS-1:0] rd_gen, gen_inc, gen_next;
  logic [TAG_W-1:0]    rd_tag;
  logic                hidx_ok, handle_ok;
  logic [IDX_W-1:0]    alloc_slot;
  logic [GEN_BITS-1:0] alloc_gen;
  logic [HW-1:0]       alloc_slot_w;
  logic [GW-1:0]       alloc_gen_w, rd_gen_w;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign fire        = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // read addresses are issued with the accepted beat
  assign hidx_in    = HW'(in_i.handle_index);
  assign slot_raddr = hidx_in[IDX_W-1:0];
  assign stk_top    = free_count_q - 1'b1;
  assign stk_raddr  = stk_top[IDX_W-1:0];

  ght_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOT_COUNT),
    .AW    (IDX_W)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (accept),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  ght_ram #(
    .WIDTH (STK_W),
    .DEPTH (SLOT_COUNT),
    .AW    (IDX_W)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (accept),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // handle check against the slot word read back
  assign hidx     = HW'(req_q.handle_index);
  assign rd_alive = slot_rdata[SLOT_W-1];
  assign rd_gen   = slot_rdata[TAG_W +: GEN_BITS];
  assign rd_tag   = slot_rdata[TAG_W-1:0];
  assign rd_gen_w = GW'(rd_gen);
  assign hidx_ok  = ((HW+1)'(hidx) < (HW+1)'(slots_used_q));
  assign handle_ok = (req_q.handle_generation != '0) && hidx_ok && rd_alive &&
                     (rd_gen_w == GW'(req_q.handle_generation));

  // generation advance skips zero
  assign gen_inc  = rd_gen + 1'b1;
  assign gen_next = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;

  // recycled slot carries its generation on the stack, a fresh slot starts at one
  always_comb begin
    if (free_count_q != '0) begin
      alloc_slot = stk_rdata[IDX_W-1:0];
      alloc_gen  = stk_rdata[STK_W-1 -: GEN_BITS];
    end else begin
      alloc_slot = slots_used_q[IDX_W-1:0];
      alloc_gen  = GEN_BITS'(1);
    end
  end

  assign alloc_slot_w = HW'(alloc_slot);
  assign alloc_gen_w  = GW'(alloc_gen);

  always_comb begin
    state_d      = state_q;
    free_count_d = free_count_q;
    slots_used_d = slots_used_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    slot_we      = 1'b0;
    slot_waddr   = alloc_slot;
    slot_wdata   = {1'b1, alloc_gen, req_q.resource_tag};
    stk_we       = 1'b0;
    stk_waddr    = free_count_q[IDX_W-1:0];
    stk_wdata    = {gen_next, hidx[IDX_W-1:0]};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_d              = S_IDLE;
          out_valid_d          = 1'b1;
          out_d.status         = ST_INVALID;
          out_d.out_index      = req_q.handle_index;
          out_d.out_generation = '0;
          out_d.out_resource   = '0;
          case (req_q.command)
            CMD_ALLOC: begin
              if (req_q.resource_tag == '0) begin
                out_d.status = ST_NULL;
              end else if (free_count_q == '0 && slots_used_q == SLOT_MAX) begin
                out_d.status = ST_FULL;
              end else begin
                if (free_count_q != '0) begin
                  free_count_d = free_count_q - 1'b1;
                end else begin
                  slots_used_d = slots_used_q + 1'b1;
                end
                slot_we              = 1'b1;
                out_d.status         = ST_OK;
                out_d.out_index      = alloc_slot_w[IDX_FIELD_W-1:0];
                out_d.out_generation = alloc_gen_w[GEN_FIELD_W-1:0];
              end
            end
            CMD_RESOLVE: begin
              if (handle_ok) begin
                out_d.status         = ST_OK;
                out_d.out_generation = rd_gen_w[GEN_FIELD_W-1:0];
                out_d.out_resource   = rd_tag;
              end
            end
            CMD_RELEASE: begin
              if (handle_ok) begin
                slot_we      = 1'b1;
                slot_waddr   = hidx[IDX_W-1:0];
                slot_wdata   = {1'b0, gen_next, {TAG_W{1'b0}}};
                out_d.status = ST_OK;
                if (free_count_q < SLOT_MAX) begin
                  stk_we       = 1'b1;
                  free_count_d = free_count_q + 1'b1;
                end
              end
            end
            default: begin
              out_d.status = ST_INVALID;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      free_count_q <= '0;
      slots_used_q <= '0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      free_count_q <= free_count_d;
      slots_used_q <= slots_used_d;
    end
  end

  // payload holds
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_i;
    end
    out_q <= out_d;
  end

endmodule

`default_nettype wire

FILE: test/tb_generational_handle_table_top.sv
// ----------------------------------------------------------------------------
// tb_generational_handle_table_top
// Self-checking bench for the generational handle table. A scoreboard class
// keeps its own copy of the slot table and free stack, predicts the response
// of every accepted command and checks response beats in order. Stimulus is
// a short directed sequence, an allocate-heavy fill up to a full table, a
// short allocate and release loop on one slot that steps its generation, and
// a mixed phase that mostly uses live handles. Both sides idle at random,
// and the receiver once holds off long enough to back up the input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_generational_handle_table_top;

  import ght_pkg::*;

  localparam int unsigned SLOT_COUNT  = 256;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  class handle_table_scoreboard;
    bit                     alive [SLOT_COUNT];
    logic [GEN_FIELD_W-1:0] slot_gen [SLOT_COUNT];
    logic [TAG_W-1:0]       slot_tag [SLOT_COUNT];
    logic [IDX_FIELD_W-1:0] free_stack [SLOT_COUNT];
    int unsigned            free_count;
    int unsigned            slots_used;
    int unsigned            errors;
    ght_out_t               pending_responses [$];

    function new();
      foreach (slot_gen[i]) begin
        alive[i]      = 1'b0;
        slot_gen[i]   = '0;
        slot_tag[i]   = '0;
        free_stack[i] = '0;
      end
      free_count = 0;
      slots_used = 0;
      errors     = 0;
    endfunction

    function bit handle_valid(logic [IDX_FIELD_W-1:0] idx, logic [GEN_FIELD_W-1:0] gen);
      return gen != '0 && idx < slots_used && alive[idx] && slot_gen[idx] == gen;
    endfunction

    function void note_command(ght_in_t beat);
      ght_out_t               resp;
      int unsigned            slot;
      logic [GEN_FIELD_W-1:0] next_gen;
      resp.status         = ST_INVALID;
      resp.out_index      = beat.handle_index;
      resp.out_generation = '0;
      resp.out_resource   = '0;
      case (beat.command)
        CMD_ALLOC: begin
          if (beat.resource_tag == '0) begin
            resp.status = ST_NULL;
          end else if (free_count == 0 && slots_used >= SLOT_COUNT) begin
            resp.status = ST_FULL;
          end else begin
            if (free_count != 0) begin
              free_count--;
              slot = 32'(free_stack[free_count]);
            end else begin
              slot = slots_used;
              slots_used++;
            end
            if (slot_gen[slot] == '0) begin
              slot_gen[slot] = GEN_FIELD_W'(1);
            end
            slot_tag[slot]      = beat.resource_tag;
            alive[slot]         = 1'b1;
            resp.status         = ST_OK;
            resp.out_index      = slot[IDX_FIELD_W-1:0];
            resp.out_generation = slot_gen[slot];
          end
        end
        CMD_RESOLVE: begin
          if (handle_valid(beat.handle_index, beat.handle_generation)) begin
            resp.status         = ST_OK;
            resp.out_generation = slot_gen[beat.handle_index];
            resp.out_resource   = slot_tag[beat.handle_index];
          end
        end
        CMD_RELEASE: begin
          if (handle_valid(beat.handle_index, beat.handle_generation)) begin
            next_gen = slot_gen[beat.handle_index] + 1'b1;
            if (next_gen == '0) begin
              next_gen = GEN_FIELD_W'(1);
            end
            slot_gen[beat.handle_index] = next_gen;
            alive[beat.handle_index]    = 1'b0;
            slot_tag[beat.handle_index] = '0;
            if (free_count < SLOT_COUNT) begin
              free_stack[free_count] = beat.handle_index;
              free_count++;
            end
            resp.status = ST_OK;
          end
        end
        default: ;
      endcase
      pending_responses = {pending_responses, resp};
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_response(ght_out_t got);
      ght_out_t want;
      if (pending_responses.size() == 0) begin
        report_mismatch($sformatf("response beat with none pending (status %0d index %0d)",
                                  got.status, got.out_index));
      end else begin
        want = pending_responses.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.out_index !== want.out_index)
          report_mismatch($sformatf("index got %0d want %0d", got.out_index, want.out_index));
        if (got.out_generation !== want.out_generation)
          report_mismatch($sformatf("generation got %0d want %0d",
                                    got.out_generation, want.out_generation));
        if (got.out_resource !== want.out_resource)
          report_mismatch($sformatf("resource got %h want %h",
                                    got.out_resource, want.out_resource));
      end
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  ght_in_t           in_i;
  logic              out_valid_o;
  logic              out_ready_i;
  ght_out_t          out_o;

  handle_table_scoreboard sb = new();
  int unsigned            cycle_count = 0;
  bit                     send_idle_on = 1'b1;
  bit                     recv_idle_on = 1'b1;
  bit                     hold_req = 1'b0;
  int unsigned            hold_left = 0;

  generational_handle_table_top #(
    .SLOT_COUNT(SLOT_COUNT),
    .GEN_BITS  (16)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_command(in_i);
      if (out_valid_o && out_ready_i) sb.check_response(out_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[generational_handle_table_top] ERROR");
      $finish;
    end
  end

  // response side: random stalls plus one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(recv_idle_on && $urandom_range(99) < 6);
      end
    end
  end

  function automatic ght_in_t make_beat(logic [CMD_W-1:0] cmd, logic [IDX_FIELD_W-1:0] idx,
                                        logic [GEN_FIELD_W-1:0] gen, logic [TAG_W-1:0] tag);
    ght_in_t b;
    b.command           = cmd;
    b.handle_index      = idx;
    b.handle_generation = gen;
    b.resource_tag      = tag;
    return b;
  endfunction

  function automatic logic [TAG_W-1:0] nonzero_tag();
    logic [TAG_W-1:0] t;
    t = $urandom;
    if (t == '0) t = 1;
    return t;
  endfunction

  function automatic logic [IDX_FIELD_W-1:0] pick_alive_slot();
    int unsigned idx;
    idx = $urandom_range(SLOT_COUNT - 1);
    if (sb.slots_used == 0) return idx[IDX_FIELD_W-1:0];
    for (int i = 0; i < 16; i++) begin
      idx = $urandom_range(sb.slots_used - 1);
      if (sb.alive[idx]) return idx[IDX_FIELD_W-1:0];
    end
    return idx[IDX_FIELD_W-1:0];
  endfunction

  // allocations and live handles, with null tags, stale handles and raw noise mixed in
  function automatic ght_in_t pick_random_beat(bit fill_bias);
    ght_in_t     b;
    int unsigned roll;
    int unsigned a_lim, r_lim, l_lim;
    roll  = $urandom_range(99);
    a_lim = fill_bias ? 85 : 30;
    r_lim = fill_bias ? 92 : 58;
    l_lim = fill_bias ? 95 : 88;
    b = make_beat(CMD_RESOLVE, IDX_FIELD_W'($urandom), GEN_FIELD_W'($urandom), $urandom);
    if (roll < a_lim) begin
      b.command      = CMD_ALLOC;
      b.resource_tag = ($urandom_range(99) < 5) ? '0 : nonzero_tag();
    end else if (roll < l_lim) begin
      b.command           = (roll < r_lim) ? CMD_RESOLVE : CMD_RELEASE;
      b.handle_index      = pick_alive_slot();
      b.handle_generation = sb.slot_gen[b.handle_index];
    end else if (roll < 95) begin
      b.command      = $urandom_range(1) ? CMD_RESOLVE : CMD_RELEASE;
      b.handle_index = pick_alive_slot();
      b.handle_generation = sb.slot_gen[b.handle_index] +
                            ($urandom_range(1) ? 16'hFFFF : 16'(1 + $urandom_range(2)));
    end else begin
      b.command = CMD_W'($urandom_range(3));
    end
    return b;
  endfunction

  // idle gaps, then returns just after a falling edge ready to drive a beat
  task automatic sender_turn();
    @(negedge clk_i);
    while (send_idle_on && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  task automatic drive_beat(ght_in_t beat);
    in_valid_i <= 1'b1;
    in_i       <= beat;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_fixed(logic [CMD_W-1:0] cmd, logic [IDX_FIELD_W-1:0] idx,
                            logic [GEN_FIELD_W-1:0] gen, logic [TAG_W-1:0] tag);
    sender_turn();
    drive_beat(make_beat(cmd, idx, gen, tag));
  endtask

  initial begin
    logic [IDX_FIELD_W-1:0] wrap_slot;
    logic [GEN_FIELD_W-1:0] g;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_i       = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, null tag, unused command, stale and reused handles
    send_fixed(CMD_RESOLVE, 8'd0,   16'd1,      32'h1234_5678);
    send_fixed(CMD_RELEASE, 8'd255, 16'hFFFF,   32'hFFFF_FFFF);
    send_fixed(CMD_ALLOC,   8'd0,   16'd0,      32'h0);
    send_fixed(CMD_UNUSED,  8'hAA,  16'hFFFF,   32'hFFFF_FFFF);
    send_fixed(CMD_ALLOC,   8'hFF,  16'hFFFF,   32'hFFFF_FFFF);
    send_fixed(CMD_ALLOC,   8'd0,   16'd0,      32'h1);
    send_fixed(CMD_RESOLVE, 8'd0,   16'd1,      32'h0);
    send_fixed(CMD_RESOLVE, 8'd0,   16'd0,      32'h0);
    send_fixed(CMD_RESOLVE, 8'd0,   16'd2,      32'h0);
    send_fixed(CMD_RESOLVE, 8'd2,   16'd1,      32'h0);
    send_fixed(CMD_RELEASE, 8'd0,   16'd1,      32'h0);
    send_fixed(CMD_RESOLVE, 8'd0,   16'd1,      32'h0);
    send_fixed(CMD_RELEASE, 8'd0,   16'd1,      32'h0);
    send_fixed(CMD_ALLOC,   8'd0,   16'd0,      32'h8000_0000);
    send_fixed(CMD_RESOLVE, 8'd0,   16'd2,      32'h0);
    send_fixed(CMD_RELEASE, 8'd1,   16'd1,      32'h0);
    send_fixed(CMD_RELEASE, 8'd0,   16'd2,      32'h0);
    send_fixed(CMD_ALLOC,   8'd0,   16'd0,      32'h5555_AAAA);
    send_fixed(CMD_ALLOC,   8'd0,   16'd0,      32'hAAAA_5555);
    send_fixed(CMD_ALLOC,   8'd0,   16'd0,      32'h0000_FFFF);
    send_fixed(CMD_RESOLVE, 8'd1,   16'd2,      32'h0);
    send_fixed(CMD_UNUSED,  8'd0,   16'd0,      32'h0);

    // fill up to a full table and keep pushing against it
    for (int n = 0; n < 420; n++) begin
      send_idle_on = !(n >= 100 && n < 250);
      recv_idle_on = send_idle_on;
      sender_turn();
      drive_beat(pick_random_beat(1'b1));
    end
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;

    // cycle one slot through a few generations
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    sender_turn();
    wrap_slot = pick_alive_slot();
    drive_beat(make_beat(CMD_RELEASE, wrap_slot, sb.slot_gen[wrap_slot], $urandom));
    repeat (8) begin
      send_fixed(CMD_ALLOC, IDX_FIELD_W'($urandom), GEN_FIELD_W'($urandom), nonzero_tag());
      sender_turn();
      g = sb.slot_gen[wrap_slot];
      if (g >= 16'hFFFE || g <= 16'd2) begin
        drive_beat(make_beat(CMD_RESOLVE, wrap_slot, g, $urandom));
        sender_turn();
      end
      drive_beat(make_beat(CMD_RELEASE, wrap_slot, sb.slot_gen[wrap_slot], $urandom));
    end
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;

    // mixed traffic, starting with a long receiver hold-off
    hold_req = 1'b1;
    for (int n = 0; n < 420; n++) begin
      sender_turn();
      drive_beat(pick_random_beat(1'b0));
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (sb.pending_responses.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("[generational_handle_table_top] OK");
    end else begin
      $display("[generational_handle_table_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
